// ===== hdl/c_subset_token_lexer_macros.svh =====
// Assertion macros for the C subset lexer checker.
// All macros sample on clk; the first two are disabled while rst is high.
`ifndef C_SUBSET_TOKEN_LEXER_MACROS_SVH
`define C_SUBSET_TOKEN_LEXER_MACROS_SVH

// Same-cycle implication.
`define CSTL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CSTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Raw property, no reset gating.
`define CSTL_ASSERT_RAW(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/cstl_pkg.sv =====
package cstl_pkg;

  // token kinds
  localparam logic [4:0] K_END   = 5'd0;
  localparam logic [4:0] K_PUNCT = 5'd1;
  localparam logic [4:0] K_NUM   = 5'd2;
  localparam logic [4:0] K_IDENT = 5'd3;
  localparam logic [4:0] K_STR   = 5'd4;
  localparam logic [4:0] K_KW0   = 5'd5;
  localparam logic [4:0] K_EQ    = 5'd14;
  localparam logic [4:0] K_AND   = 5'd15;
  localparam logic [4:0] K_OR    = 5'd16;
  localparam logic [4:0] K_INC   = 5'd17;
  localparam logic [4:0] K_DEC   = 5'd18;
  localparam logic [4:0] K_TEXT  = 5'd19;
  localparam logic [4:0] K_ERR   = 5'd20;

  localparam int NUM_KW = 9;
  localparam logic [23:0] LINE_TOP = 24'hFF_FFFF;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_IDSKIP,
    MODE_NUM,
    MODE_STR,
    MODE_STRESC,
    MODE_STRSKIP,
    MODE_EQ,
    MODE_PLUS,
    MODE_MINUS,
    MODE_AMP,
    MODE_BAR,
    MODE_SLASH,
    MODE_LCOM,
    MODE_BCOM,
    MODE_BSTAR
  } mode_t;

  // keyword spelling, zero padded to 8 characters
  localparam logic [7:0] KW_TEXT [0:NUM_KW-1][0:7] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", "r", "i", "n", "t", "f", 8'h00, 8'h00},
    '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"s", "t", "r", "u", "c", "t", 8'h00, 8'h00}
  };

  localparam logic [3:0] KW_LEN [0:NUM_KW-1] = '{
    4'd3, 4'd2, 4'd4, 4'd5, 4'd3, 4'd6, 4'd4, 4'd6, 4'd6
  };

  typedef struct packed {
    logic [4:0]         kind;
    logic signed [31:0] value;
    logic [7:0]         char_code;
    logic [23:0]        line_no;
    logic               last_of_step;
  } tok_t;

  // results of one source byte
  typedef struct packed {
    tok_t       tok0;
    tok_t       tok1;
    logic [1:0] cnt;
  } res_t;

endpackage

// ===== hdl/cstl_if.sv =====
interface cstl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;

  modport source (output valid, output src_byte, input ready);
  modport sink (input valid, input src_byte, output ready);
endinterface

interface cstl_tok_if;
  logic               valid;
  logic               ready;
  logic [4:0]         kind;
  logic signed [31:0] value;
  logic [7:0]         char_code;
  logic [23:0]        line_no;
  logic               last_of_step;

  modport source (output valid, output kind, output value, output char_code,
                  output line_no, output last_of_step, input ready);
  modport sink (input valid, input kind, input value, input char_code,
                input line_no, input last_of_step, output ready);
endinterface

// ===== hdl/cstl_core.sv =====
module cstl_core #(
  parameter int IDENT_MAX  = 32,
  parameter int STRING_MAX = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       src_byte,
  output cstl_pkg::res_t   res
);

  localparam logic [7:0] ID_LIM  = 8'(IDENT_MAX - 1);
  localparam logic [7:0] STR_LIM = 8'(STRING_MAX - 1);

  cstl_pkg::mode_t   mode, mode_next;
  logic [31:0]       acc, acc_next;
  logic              neg, neg_next;
  logic [8:0]        cand, cand_next;
  logic [7:0]        tlen, tlen_next;
  logic [23:0]       line, line_next;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [23:0] line_up(input logic [23:0] l);
    return (l == cstl_pkg::LINE_TOP) ? l : l + 24'd1;
  endfunction

  function automatic cstl_pkg::tok_t mk_tok(input logic [4:0] k, input logic [31:0] v,
                                            input logic [7:0] c, input logic [23:0] l);
    cstl_pkg::tok_t t;
    t.kind         = k;
    t.value        = v;
    t.char_code    = c;
    t.line_no      = l;
    t.last_of_step = 1'b0;
    return t;
  endfunction

  function automatic logic [4:0] close_kind(input logic [8:0] cm, input logic [7:0] tl);
    logic [4:0] kd;
    kd = cstl_pkg::K_IDENT;
    for (int k = 0; k < cstl_pkg::NUM_KW; k++) begin
      if (cm[k] && {4'b0, cstl_pkg::KW_LEN[k]} == tl) kd = cstl_pkg::K_KW0 + 5'(k);
    end
    return kd;
  endfunction

  always_comb begin
    cstl_pkg::mode_t  m;
    logic [31:0]      a;
    logic             ng;
    logic [8:0]       cm;
    logic [7:0]       tl;
    logic [23:0]      ln;
    logic [7:0]       b;
    logic [31:0]      d;
    logic [1:0]       n;
    logic             idle_go, str_go, s1_go, iadd_go;
    logic [7:0]       s1_ch;
    cstl_pkg::tok_t   r [0:1];

    m  = mode;
    a  = acc;
    ng = neg;
    cm = cand;
    tl = tlen;
    ln = line;
    b  = src_byte;
    d  = 32'(b - "0");
    n  = 2'd0;
    r[0] = '0;
    r[1] = '0;
    idle_go = 1'b0;
    str_go  = 1'b0;
    s1_go   = 1'b0;
    iadd_go = 1'b0;
    s1_ch   = 8'h00;

    if (b == 8'h00) begin
      // end of text: flush, end token, back to reset values
      case (m)
        cstl_pkg::MODE_IDENT: begin
          r[n[0]] = mk_tok(close_kind(cm, tl), 32'd0, 8'h00, ln); n = n + 2'd1;
        end
        cstl_pkg::MODE_NUM: begin
          r[n[0]] = mk_tok(cstl_pkg::K_NUM, ng ? 32'd0 - a : a, 8'h00, ln); n = n + 2'd1;
        end
        cstl_pkg::MODE_STR, cstl_pkg::MODE_STRESC: begin
          r[n[0]] = mk_tok(cstl_pkg::K_ERR, 32'd0, "\"", ln); n = n + 2'd1;
        end
        cstl_pkg::MODE_EQ: begin
          r[n[0]] = mk_tok(cstl_pkg::K_PUNCT, 32'd0, "=", ln); n = n + 2'd1;
        end
        cstl_pkg::MODE_PLUS: begin
          r[n[0]] = mk_tok(cstl_pkg::K_PUNCT, 32'd0, "+", ln); n = n + 2'd1;
        end
        cstl_pkg::MODE_MINUS: begin
          r[n[0]] = mk_tok(cstl_pkg::K_PUNCT, 32'd0, "-", ln); n = n + 2'd1;
        end
        cstl_pkg::MODE_SLASH: begin
          r[n[0]] = mk_tok(cstl_pkg::K_PUNCT, 32'd0, "/", ln); n = n + 2'd1;
        end
        cstl_pkg::MODE_AMP: begin
          r[n[0]] = mk_tok(cstl_pkg::K_ERR, 32'd0, "&", ln); n = n + 2'd1;
        end
        cstl_pkg::MODE_BAR: begin
          r[n[0]] = mk_tok(cstl_pkg::K_ERR, 32'd0, "|", ln); n = n + 2'd1;
        end
        default: begin
        end
      endcase
      r[n[0]] = mk_tok(cstl_pkg::K_END, 32'd0, 8'h00, ln); n = n + 2'd1;
      m  = cstl_pkg::MODE_IDLE;
      a  = 32'd0;
      ng = 1'b0;
      cm = '1;
      tl = 8'd0;
      ln = 24'd1;
    end else begin
      case (m)
        cstl_pkg::MODE_IDENT: begin
          if (is_letter(b) || is_digit(b)) begin
            iadd_go = 1'b1;
          end else begin
            r[n[0]] = mk_tok(close_kind(cm, tl), 32'd0, 8'h00, ln); n = n + 2'd1;
            idle_go = 1'b1;
          end
        end
        cstl_pkg::MODE_IDSKIP: begin
          if (!(is_letter(b) || is_digit(b))) idle_go = 1'b1;
        end
        cstl_pkg::MODE_NUM: begin
          if (is_digit(b)) begin
            a = {a[28:0], 3'b000} + {a[30:0], 1'b0} + d;
          end else begin
            r[n[0]] = mk_tok(cstl_pkg::K_NUM, ng ? 32'd0 - a : a, 8'h00, ln); n = n + 2'd1;
            idle_go = 1'b1;
          end
        end
        cstl_pkg::MODE_STR, cstl_pkg::MODE_STRSKIP: begin
          str_go = 1'b1;
        end
        cstl_pkg::MODE_STRESC: begin
          m     = cstl_pkg::MODE_STR;
          s1_go = 1'b1;
          if (b == "n") begin
            s1_ch = 8'h0A;
          end else if (b == "t") begin
            s1_ch = 8'h09;
          end else begin
            // backslash kept, byte then lexed as in the string body
            s1_ch  = "\\";
            str_go = 1'b1;
          end
        end
        cstl_pkg::MODE_EQ: begin
          if (b == "=") begin
            r[n[0]] = mk_tok(cstl_pkg::K_EQ, 32'd0, 8'h00, ln); n = n + 2'd1;
            m = cstl_pkg::MODE_IDLE;
          end else begin
            r[n[0]] = mk_tok(cstl_pkg::K_PUNCT, 32'd0, "=", ln); n = n + 2'd1;
            idle_go = 1'b1;
          end
        end
        cstl_pkg::MODE_PLUS, cstl_pkg::MODE_MINUS: begin
          if (b == ((m == cstl_pkg::MODE_PLUS) ? "+" : "-")) begin
            r[n[0]] = mk_tok((m == cstl_pkg::MODE_PLUS) ? cstl_pkg::K_INC : cstl_pkg::K_DEC,
                             32'd0, 8'h00, ln);
            n = n + 2'd1;
            m = cstl_pkg::MODE_IDLE;
          end else if (is_digit(b)) begin
            // sign folds into the number
            ng = (m == cstl_pkg::MODE_MINUS);
            a  = d;
            m  = cstl_pkg::MODE_NUM;
          end else begin
            r[n[0]] = mk_tok(cstl_pkg::K_PUNCT, 32'd0,
                             (m == cstl_pkg::MODE_PLUS) ? "+" : "-", ln);
            n = n + 2'd1;
            idle_go = 1'b1;
          end
        end
        cstl_pkg::MODE_AMP: begin
          if (b == "&") begin
            r[n[0]] = mk_tok(cstl_pkg::K_AND, 32'd0, 8'h00, ln); n = n + 2'd1;
            m = cstl_pkg::MODE_IDLE;
          end else begin
            r[n[0]] = mk_tok(cstl_pkg::K_ERR, 32'd0, "&", ln); n = n + 2'd1;
            idle_go = 1'b1;
          end
        end
        cstl_pkg::MODE_BAR: begin
          if (b == "|") begin
            r[n[0]] = mk_tok(cstl_pkg::K_OR, 32'd0, 8'h00, ln); n = n + 2'd1;
            m = cstl_pkg::MODE_IDLE;
          end else begin
            r[n[0]] = mk_tok(cstl_pkg::K_ERR, 32'd0, "|", ln); n = n + 2'd1;
            idle_go = 1'b1;
          end
        end
        cstl_pkg::MODE_SLASH: begin
          if (b == "/") begin
            m = cstl_pkg::MODE_LCOM;
          end else if (b == "*") begin
            m = cstl_pkg::MODE_BCOM;
          end else begin
            r[n[0]] = mk_tok(cstl_pkg::K_PUNCT, 32'd0, "/", ln); n = n + 2'd1;
            idle_go = 1'b1;
          end
        end
        cstl_pkg::MODE_LCOM: begin
          if (b == 8'h0A) begin
            ln = line_up(ln);
            m  = cstl_pkg::MODE_IDLE;
          end
        end
        cstl_pkg::MODE_BCOM: begin
          if (b == "*") m = cstl_pkg::MODE_BSTAR;
          else if (b == 8'h0A) ln = line_up(ln);
        end
        cstl_pkg::MODE_BSTAR: begin
          if (b == "/") begin
            m = cstl_pkg::MODE_IDLE;
          end else if (b != "*") begin
            if (b == 8'h0A) ln = line_up(ln);
            m = cstl_pkg::MODE_BCOM;
          end
        end
        default: begin
          idle_go = 1'b1;
        end
      endcase

      // escape result or kept backslash
      if (s1_go) begin
        if (tl >= STR_LIM) begin
          r[n[0]] = mk_tok(cstl_pkg::K_ERR, 32'd0, s1_ch, ln); n = n + 2'd1;
          m = cstl_pkg::MODE_STRSKIP;
        end else begin
          tl = tl + 8'd1;
          r[n[0]] = mk_tok(cstl_pkg::K_TEXT, 32'd0, s1_ch, ln); n = n + 2'd1;
        end
      end

      // string body
      if (str_go) begin
        if (m == cstl_pkg::MODE_STRSKIP) begin
          if (b == "\"") m = cstl_pkg::MODE_IDLE;
          else if (b == 8'h0A) ln = line_up(ln);
        end else if (b == "\"") begin
          r[n[0]] = mk_tok(cstl_pkg::K_STR, 32'd0, 8'h00, ln); n = n + 2'd1;
          m = cstl_pkg::MODE_IDLE;
        end else if (b == "\\") begin
          m = cstl_pkg::MODE_STRESC;
        end else begin
          if (b == 8'h0A) ln = line_up(ln);
          if (tl >= STR_LIM) begin
            r[n[0]] = mk_tok(cstl_pkg::K_ERR, 32'd0, b, ln); n = n + 2'd1;
            m = cstl_pkg::MODE_STRSKIP;
          end else begin
            tl = tl + 8'd1;
            r[n[0]] = mk_tok(cstl_pkg::K_TEXT, 32'd0, b, ln); n = n + 2'd1;
          end
        end
      end

      // fresh token start
      if (idle_go) begin
        m = cstl_pkg::MODE_IDLE;
        if (is_letter(b)) begin
          m       = cstl_pkg::MODE_IDENT;
          tl      = 8'd0;
          cm      = '1;
          iadd_go = 1'b1;
        end else if (is_digit(b)) begin
          m  = cstl_pkg::MODE_NUM;
          a  = d;
          ng = 1'b0;
        end else if (b == "\"") begin
          m  = cstl_pkg::MODE_STR;
          tl = 8'd0;
        end else if (b == "=") begin
          m = cstl_pkg::MODE_EQ;
        end else if (b == "+") begin
          m = cstl_pkg::MODE_PLUS;
        end else if (b == "-") begin
          m = cstl_pkg::MODE_MINUS;
        end else if (b == "&") begin
          m = cstl_pkg::MODE_AMP;
        end else if (b == "|") begin
          m = cstl_pkg::MODE_BAR;
        end else if (b == "/") begin
          m = cstl_pkg::MODE_SLASH;
        end else if (b == ">" || b == "<" || b == "*" || b == "[" || b == "]" ||
                     b == "{" || b == "}" || b == "(" || b == ")" || b == ";" ||
                     b == "," || b == ".") begin
          r[n[0]] = mk_tok(cstl_pkg::K_PUNCT, 32'd0, b, ln); n = n + 2'd1;
        end else if (b == " " || b == 8'h09) begin
          m = cstl_pkg::MODE_IDLE;
        end else if (b == 8'h0A) begin
          ln = line_up(ln);
        end else begin
          r[n[0]] = mk_tok(cstl_pkg::K_ERR, 32'd0, b, ln); n = n + 2'd1;
        end
      end

      // identifier character with keyword narrowing
      if (iadd_go) begin
        if (tl >= ID_LIM) begin
          r[n[0]] = mk_tok(cstl_pkg::K_ERR, 32'd0, b, ln); n = n + 2'd1;
          m = cstl_pkg::MODE_IDSKIP;
        end else begin
          for (int k = 0; k < cstl_pkg::NUM_KW; k++) begin
            if (!({4'b0, cstl_pkg::KW_LEN[k]} > tl &&
                  cstl_pkg::KW_TEXT[k][tl[2:0]] == b)) cm[k] = 1'b0;
          end
          tl = tl + 8'd1;
          r[n[0]] = mk_tok(cstl_pkg::K_TEXT, 32'd0, b, ln); n = n + 2'd1;
        end
      end
    end

    if (n == 2'd1) r[0].last_of_step = 1'b1;
    if (n == 2'd2) r[1].last_of_step = 1'b1;

    res.tok0  = r[0];
    res.tok1  = r[1];
    res.cnt   = n;
    mode_next = m;
    acc_next  = a;
    neg_next  = ng;
    cand_next = cm;
    tlen_next = tl;
    line_next = ln;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= cstl_pkg::MODE_IDLE;
      acc  <= 32'd0;
      neg  <= 1'b0;
      cand <= '1;
      tlen <= 8'd0;
      line <= 24'd1;
    end else if (fire) begin
      mode <= mode_next;
      acc  <= acc_next;
      neg  <= neg_next;
      cand <= cand_next;
      tlen <= tlen_next;
      line <= line_next;
    end
  end

endmodule

// ===== hdl/cstl_queue.sv =====
module cstl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cstl_pkg::res_t  res,
  input  logic            head_ready,
  output cstl_pkg::tok_t  head,
  output logic            head_valid,
  output logic            room
);

  localparam int DEPTH = 3;

  cstl_pkg::tok_t slot [0:DEPTH-1];
  cstl_pkg::tok_t slot_next [0:DEPTH-1];
  logic [1:0]     cnt, cnt_next;
  logic           pop;
  logic [1:0]     base;
  logic [1:0]     add;

  assign head_valid = (cnt != 2'd0);
  assign head       = slot[0];
  assign pop        = head_valid && head_ready;
  assign base       = cnt - {1'b0, pop};
  // two free slots needed for the worst-case byte
  assign room       = (base <= 2'd1);
  assign add        = push ? res.cnt : 2'd0;
  assign cnt_next   = base + add;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (pop && i < DEPTH - 1) slot_next[i] = slot[i + 1];
      else slot_next[i] = slot[i];
      if (push && res.cnt != 2'd0 && base == 2'(i)) slot_next[i] = res.tok0;
      if (push && res.cnt == 2'd2 && base + 2'd1 == 2'(i)) slot_next[i] = res.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) slot[i] <= slot_next[i];
  end

endmodule

// ===== hdl/c_subset_token_lexer.sv =====
// A byte enters the input register; the lexer step writes its tokens into the
//   3-entry token queue, whose head drives tok. Throughput: one source byte per
//   cycle while the queue has room; two tokens of a byte leave in turn on tok.
// Reset (rst, synchronous, active high): lexer back to idle, line 1, input
//   register and token queue emptied. Byte 0 ends the text and also restores it.
module c_subset_token_lexer #(
  parameter int IDENT_MAX  = 32,
  parameter int STRING_MAX = 128
) (
  input logic         clk,
  input logic         rst,
  cstl_byte_if.sink   src,
  cstl_tok_if.source  tok
);

  // Input register: one source byte waiting for the lexer.
  logic        in_full;
  logic [7:0]  in_byte;

  // Lexer step fires when a byte is held and the queue can take two more tokens.
  logic            fire;
  logic            room;
  cstl_pkg::res_t  res;
  cstl_pkg::tok_t  head;
  logic            head_valid;

  assign fire      = in_full && room;
  // A new byte may enter while the held one moves into the lexer this cycle.
  assign src.ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (src.valid && src.ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src.valid && src.ready) in_byte <= src.src_byte;
  end

  // Lexer state machine and per-byte token generation (up to two tokens).
  cstl_core #(
    .IDENT_MAX  (IDENT_MAX),
    .STRING_MAX (STRING_MAX)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .src_byte (in_byte),
    .res      (res)
  );

  // Token queue: decouples the lexer from a stalled consumer.
  cstl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fire),
    .res        (res),
    .head_ready (tok.ready),
    .head       (head),
    .head_valid (head_valid),
    .room       (room)
  );

  assign tok.valid        = head_valid;
  assign tok.kind         = head.kind;
  assign tok.value        = head.value;
  assign tok.char_code    = head.char_code;
  assign tok.line_no      = head.line_no;
  assign tok.last_of_step = head.last_of_step;

endmodule

// ===== hdl/cstl_checker.sv =====
`include "c_subset_token_lexer_macros.svh"

module cstl_checker (
  input logic               clk,
  input logic               rst,
  input logic               tok_valid,
  input logic               tok_ready,
  input logic [4:0]         kind,
  input logic signed [31:0] value,
  input logic [7:0]         char_code,
  input logic [23:0]        line_no,
  input logic               last_of_step
);

  `CSTL_ASSERT_NEXT(a_tok_hold, tok_valid && !tok_ready, tok_valid && $stable(kind) && $stable(value) && $stable(char_code) && $stable(line_no) && $stable(last_of_step), "token changed while stalled")
  `CSTL_ASSERT_NOW(a_end_last, tok_valid && kind == cstl_pkg::K_END, last_of_step && value == 32'sd0 && char_code == 8'h00, "end token malformed")
  `CSTL_ASSERT_NOW(a_value_num, tok_valid && kind != cstl_pkg::K_NUM, value == 32'sd0, "value on non-number token")
  `CSTL_ASSERT_NOW(a_line_nz, tok_valid, line_no != 24'd0, "line number zero")
  `CSTL_ASSERT_RAW(a_rst_empty, $past(rst) |-> !tok_valid, "token right after reset")

endmodule

bind c_subset_token_lexer cstl_checker u_cstl_checker (
  .clk          (clk),
  .rst          (rst),
  .tok_valid    (tok.valid),
  .tok_ready    (tok.ready),
  .kind         (tok.kind),
  .value        (tok.value),
  .char_code    (tok.char_code),
  .line_no      (tok.line_no),
  .last_of_step (tok.last_of_step)
);
